// ===== rtl/keyed_record_table_unit_defines.svh =====
// Assertion macros for the keyed record table.
`ifndef KEYED_RECORD_TABLE_UNIT_DEFINES_SVH
`define KEYED_RECORD_TABLE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define KRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KRT_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KRT_ASSERT(lbl, clk, rst_n, prop, msg)
`define KRT_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/krt_pkg.sv =====
package krt_pkg;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_UPD  = 2'd2,
        OP_READ = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [6:0] CAPACITY_RESET = 7'd64;

    typedef struct packed {
        logic rotate;
        logic del;
        logic wr;
    } t_cell_ctl;

endpackage

// ===== rtl/krt_cell.sv =====
module krt_cell #(
    parameter int IDXW = 6,
    parameter int IDX  = 0
) (
    input  logic               i_clk,
    input  krt_pkg::t_cell_ctl i_ctl,
    input  logic [IDXW-1:0]    i_sel,
    input  logic [31:0]        i_nb_key,
    input  logic [63:0]        i_nb_pay,
    input  logic [31:0]        i_wr_key,
    input  logic [63:0]        i_wr_pay,
    output logic [31:0]        o_key,
    output logic [63:0]        o_pay
);
    import krt_pkg::*;

    localparam logic [IDXW-1:0] MyIdx = IDXW'(IDX);

    logic        w_shift;
    logic        w_wr;
    logic [31:0] r_key;
    logic [63:0] r_pay;

    assign w_shift = i_ctl.rotate || (i_ctl.del && (i_sel <= MyIdx));
    assign w_wr    = i_ctl.wr && (i_sel == MyIdx);

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key <= i_nb_key;
            r_pay <= i_nb_pay;
        end else if (w_wr) begin
            r_key <= i_wr_key;
            r_pay <= i_wr_pay;
        end
    end

    assign o_key = r_key;
    assign o_pay = r_pay;

endmodule

// ===== rtl/keyed_record_table_unit.sv =====
// Channel   | Direction | Handshake          | Beat
// ----------+-----------+--------------------+--------------------------------------
// request   | in        | i_valid / o_ready  | i_operation i_key i_new_key i_payload
// response  | out       | o_valid / i_ready  | o_status o_found_key o_found_payload
//           |           |                    | o_record_count
// config    | in        | APB psel / penable | capacity at address 0
//
// A request rotates the ring of cells a full turn past the compare head in the scan
// state, applies the result in the apply state, then returns to idle.
// Synchronous active-low reset clears control state and sets capacity to 64;
// the record cells need no clearing.
// A stalled response holds the apply step until the output register frees up.
`include "keyed_record_table_unit_defines.svh"

module keyed_record_table_unit #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_new_key,
    input  logic [63:0]        i_payload,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_found_key,
    output logic [63:0]        o_found_payload,
    output logic [6:0]         o_record_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import krt_pkg::*;

    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int MW   = (CW > 7) ? CW : 7;
    localparam logic [IDXW-1:0] LastIdx = IDXW'(DEPTH - 1);

    t_state          r_state;
    logic [IDXW-1:0] r_idx;
    logic [CW-1:0]   r_count;
    logic [6:0]      r_capacity;
    t_op             r_op;
    logic [31:0]     r_key;
    logic [31:0]     r_new_key;
    logic [63:0]     r_pay;
    logic            r_hit_k;
    logic            r_hit_nk;
    logic [IDXW-1:0] r_slot;
    logic [31:0]     r_fkey;
    logic [63:0]     r_fpay;
    logic            r_o_valid;
    t_status         r_o_status;
    logic [31:0]     r_o_fkey;
    logic [63:0]     r_o_fpay;
    logic [CW-1:0]   r_o_count;

    logic [31:0]     w_key [DEPTH];
    logic [63:0]     w_pay [DEPTH];
    t_cell_ctl       w_ctl;
    logic            w_accept;
    logic            w_fire;
    logic            w_in_range;
    logic            w_full;
    t_status         w_status;
    logic            w_wr;
    logic            w_del;
    logic            w_found;
    logic [IDXW-1:0] w_sel;
    logic [31:0]     w_wkey;
    logic [CW-1:0]   n_count;
    logic            w_cfg_wr;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_fire     = (r_state == S_APPLY) && (!r_o_valid || i_ready);
    assign w_in_range = (CW'(r_idx) < r_count);
    assign w_full     = (MW'(r_count) >= MW'(r_capacity)) || (r_count >= CW'(DEPTH));

    assign w_ctl.rotate = (r_state == S_SCAN);
    assign w_ctl.del    = w_fire && w_del;
    assign w_ctl.wr     = w_fire && w_wr;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            localparam int Nx = (gi + 1) % DEPTH;
            krt_cell #(
                .IDXW (IDXW),
                .IDX  (gi)
            ) u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl),
                .i_sel    (w_sel),
                .i_nb_key (w_key[Nx]),
                .i_nb_pay (w_pay[Nx]),
                .i_wr_key (w_wkey),
                .i_wr_pay (r_pay),
                .o_key    (w_key[gi]),
                .o_pay    (w_pay[gi])
            );
        end
    endgenerate

    always_comb begin
        w_status = ST_OK;
        w_wr     = 1'b0;
        w_del    = 1'b0;
        w_found  = 1'b0;
        w_sel    = r_slot;
        w_wkey   = r_new_key;
        n_count  = r_count;
        case (r_op)
            OP_ADD: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (r_hit_k) begin
                    w_status = ST_DUP;
                end else begin
                    w_wr    = 1'b1;
                    w_sel   = r_count[IDXW-1:0];
                    w_wkey  = r_key;
                    n_count = r_count + CW'(1);
                end
            end
            OP_DEL: begin
                if (!r_hit_k) begin
                    w_status = ST_MISSING;
                end else begin
                    w_del   = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            OP_UPD: begin
                if (r_hit_nk) begin
                    w_status = ST_DUP;
                end else if (!r_hit_k) begin
                    w_status = ST_MISSING;
                end else begin
                    w_wr = 1'b1;
                end
            end
            OP_READ: begin
                if (!r_hit_k) begin
                    w_status = ST_MISSING;
                end else begin
                    w_found = 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_hit_k   <= 1'b0;
            r_hit_nk  <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && !w_fire) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state  <= S_SCAN;
                        r_idx    <= '0;
                        r_hit_k  <= 1'b0;
                        r_hit_nk <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (w_in_range) begin
                        if (!r_hit_k && (w_key[0] == r_key)) begin
                            r_hit_k <= 1'b1;
                        end
                        if (w_key[0] == r_new_key) begin
                            r_hit_nk <= 1'b1;
                        end
                    end
                    if (r_idx == LastIdx) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_idx <= r_idx + IDXW'(1);
                    end
                end
                S_APPLY: begin
                    if (w_fire) begin
                        r_count   <= n_count;
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= t_op'(i_operation);
            r_key     <= i_key;
            r_new_key <= i_new_key;
            r_pay     <= i_payload;
        end
        if ((r_state == S_SCAN) && w_in_range && !r_hit_k && (w_key[0] == r_key)) begin
            r_slot <= r_idx;
            r_fkey <= w_key[0];
            r_fpay <= w_pay[0];
        end
        if (w_fire) begin
            r_o_status <= w_status;
            r_o_fkey   <= w_found ? r_fkey : '0;
            r_o_fpay   <= w_found ? r_fpay : '0;
            r_o_count  <= n_count;
        end
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (w_cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {25'd0, r_capacity} : '0;

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_found_key     = r_o_fkey;
    assign o_found_payload = r_o_fpay;
    assign o_record_count  = 7'(r_o_count);

    `KRT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count above depth")
    `KRT_ASSERT(a_scan_start, i_clk, i_rst_n, w_accept |=> (r_state == S_SCAN && r_idx == '0), "scan did not start at slot zero")
    `KRT_ASSERT(a_out_from_apply, i_clk, i_rst_n, $rose(r_o_valid) |-> $past(w_fire), "response without apply")
    `KRT_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_o_valid), "reset left block busy")

endmodule

// ===== tb/keyed_record_table_unit_test.sv =====
`timescale 1ns / 100ps

module keyed_record_table_unit_test;
    import krt_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [2:0] ADDR_CAPACITY = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    typedef struct {
        t_op         op;
        logic [31:0] key;
        logic [31:0] new_key;
        logic [63:0] payload;
    } t_table_req;

    typedef struct {
        t_status     status;
        logic [31:0] found_key;
        logic [63:0] found_payload;
        logic [6:0]  record_count;
    } t_table_resp;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_operation = '0;
    logic signed [31:0] i_key = '0;
    logic signed [31:0] i_new_key = '0;
    logic [63:0]        i_payload = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_found_key;
    logic [63:0]        o_found_payload;
    logic [6:0]         o_record_count;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    keyed_record_table_unit #(.DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_key(i_key), .i_new_key(i_new_key),
        .i_payload(i_payload),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_found_key(o_found_key),
        .o_found_payload(o_found_payload), .o_record_count(o_record_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    t_table_req  pending_reqs[$];
    t_table_resp expected_resps[$];
    t_table_req  driven_req;

    logic [31:0] tbl_key[DEPTH];
    logic [63:0] tbl_payload[DEPTH];
    int          tbl_count = 0;
    logic [6:0]  capacity_reg = CAPACITY_RESET;

    logic [31:0] key_pool[$];
    logic        steady = 1'b0;
    int          fail_count = 0;
    int          cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit idle_now();
        return !steady && ($urandom_range(0, 99) < 11);
    endfunction

    function automatic int slot_of(logic [31:0] k);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic void apply_request(t_table_req r);
        t_table_resp e;
        int          s;
        int          lim;
        e.status = ST_OK;
        e.found_key = '0;
        e.found_payload = '0;
        lim = (capacity_reg < DEPTH) ? int'(capacity_reg) : DEPTH;
        case (r.op)
            OP_ADD: begin
                if (tbl_count >= lim) begin
                    e.status = ST_FULL;
                end else if (slot_of(r.key) >= 0) begin
                    e.status = ST_DUP;
                end else begin
                    tbl_key[tbl_count] = r.key;
                    tbl_payload[tbl_count] = r.payload;
                    tbl_count++;
                end
            end
            OP_DEL: begin
                s = slot_of(r.key);
                if (s < 0) begin
                    e.status = ST_MISSING;
                end else begin
                    for (int j = s; j + 1 < tbl_count; j++) begin
                        tbl_key[j] = tbl_key[j + 1];
                        tbl_payload[j] = tbl_payload[j + 1];
                    end
                    tbl_count--;
                end
            end
            OP_UPD: begin
                if (slot_of(r.new_key) >= 0) begin
                    e.status = ST_DUP;
                end else begin
                    s = slot_of(r.key);
                    if (s < 0) begin
                        e.status = ST_MISSING;
                    end else begin
                        tbl_key[s] = r.new_key;
                        tbl_payload[s] = r.payload;
                    end
                end
            end
            default: begin
                s = slot_of(r.key);
                if (s < 0) begin
                    e.status = ST_MISSING;
                end else begin
                    e.found_key = tbl_key[s];
                    e.found_payload = tbl_payload[s];
                end
            end
        endcase
        e.record_count = tbl_count[6:0];
        expected_resps.push_back(e);
    endfunction

    task automatic queue_req(t_op op, logic [31:0] k, logic [31:0] nk, logic [63:0] pl);
        t_table_req r;
        r.op = op;
        r.key = k;
        r.new_key = nk;
        r.payload = pl;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_resps.size() != 0 || i_valid)
            @(negedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if ((addr >> 2) == ADDR_CAPACITY) capacity_reg = data[6:0];
    endtask

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50 && tbl_count > 0) return tbl_key[$urandom_range(0, tbl_count - 1)];
        if (r < 85) return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom;
    endfunction

    task automatic run_phase(logic [6:0] cap, int pool_n, int add_pct, int n_items);
        int          r;
        t_op         op;
        logic [31:0] k;
        logic [31:0] nk;
        wait_drained();
        write_reg(ADDR_CAPACITY, {25'($urandom_range(0, 33554431)), cap});
        key_pool.delete();
        for (int i = 0; i < pool_n; i++) begin
            case ($urandom_range(0, 19))
                0: key_pool.push_back(32'h8000_0000);
                1: key_pool.push_back(32'h7fff_ffff);
                2: key_pool.push_back(32'h0000_0000);
                3: key_pool.push_back(32'hffff_ffff);
                default: key_pool.push_back($urandom);
            endcase
        end
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct) op = OP_ADD;
            else if (r < add_pct + (100 - add_pct) / 3) op = OP_DEL;
            else if (r < add_pct + 2 * (100 - add_pct) / 3) op = OP_UPD;
            else op = OP_READ;
            k = pick_key();
            nk = ($urandom_range(0, 99) < 70) ? pick_key() : $urandom;
            queue_req(op, k, nk, {$urandom, $urandom});
            // predictor state at generation time only steers key choice
            while (pending_reqs.size() > 4) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) apply_request(driven_req);
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() > 0 && !idle_now()) begin
                    driven_req = pending_reqs.pop_front();
                    i_operation <= driven_req.op;
                    i_key       <= driven_req.key;
                    i_new_key   <= driven_req.new_key;
                    i_payload   <= driven_req.payload;
                    i_valid     <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_table_resp e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_resps.size() == 0) begin
                $error("unexpected response beat: status %0d", o_status);
                fail_count++;
            end else begin
                e = expected_resps.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, o_status);
                    fail_count++;
                end
                if (o_found_key !== e.found_key) begin
                    $error("found_key: expected %h, actual %h", e.found_key, o_found_key);
                    fail_count++;
                end
                if (o_found_payload !== e.found_payload) begin
                    $error("found_payload: expected %h, actual %h",
                           e.found_payload, o_found_payload);
                    fail_count++;
                end
                if (o_record_count !== e.record_count) begin
                    $error("record_count: expected %0d, actual %0d",
                           e.record_count, o_record_count);
                    fail_count++;
                end
            end
        end
        i_ready <= !idle_now();
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table
        queue_req(OP_READ, 32'h0000_0005, 32'h0, 64'h0);
        queue_req(OP_DEL,  32'h0000_0005, 32'h0, 64'h0);
        queue_req(OP_UPD,  32'h0000_0005, 32'h6, 64'h1);
        // key extremes
        queue_req(OP_ADD,  32'h8000_0000, 32'hffff_ffff, 64'h0);
        queue_req(OP_ADD,  32'h7fff_ffff, 32'h0, 64'hffff_ffff_ffff_ffff);
        queue_req(OP_ADD,  32'hffff_ffff, 32'h0, 64'h8000_0000_0000_0001);
        queue_req(OP_ADD,  32'h0000_0000, 32'h0, 64'h0123_4567_89ab_cdef);
        queue_req(OP_ADD,  32'h7fff_ffff, 32'h0, 64'h5555_5555_5555_5555);
        queue_req(OP_READ, 32'h8000_0000, 32'h0, 64'h0);
        queue_req(OP_READ, 32'h7fff_ffff, 32'h0, 64'h0);
        queue_req(OP_READ, 32'h0000_0005, 32'h0, 64'h0);
        // update: duplicate on another entry, on the target itself, missing key, then a rename
        queue_req(OP_UPD,  32'h7fff_ffff, 32'hffff_ffff, 64'h1);
        queue_req(OP_UPD,  32'h7fff_ffff, 32'h7fff_ffff, 64'h1);
        queue_req(OP_UPD,  32'h0000_0005, 32'h0000_0006, 64'h1);
        queue_req(OP_UPD,  32'h0000_0000, 32'h1234_5678, 64'ha5a5_a5a5_a5a5_a5a5);
        queue_req(OP_READ, 32'h1234_5678, 32'h0, 64'h0);
        // delete from the head, shift the rest down, then delete the same key again
        queue_req(OP_DEL,  32'h8000_0000, 32'h0, 64'h0);
        queue_req(OP_READ, 32'hffff_ffff, 32'h0, 64'h0);
        queue_req(OP_DEL,  32'h8000_0000, 32'h0, 64'h0);
        queue_req(OP_READ, 32'h1234_5678, 32'h0, 64'h0);

        // capacity zero: every add is full
        wait_drained();
        write_reg(ADDR_CAPACITY, 32'd0);
        queue_req(OP_ADD,  32'h0000_0042, 32'h0, 64'h42);
        queue_req(OP_READ, 32'h7fff_ffff, 32'h0, 64'h0);

        // capacity below count: records stay, adds are full
        wait_drained();
        write_reg(ADDR_CAPACITY, 32'd2);
        queue_req(OP_ADD,  32'h0000_0043, 32'h0, 64'h43);
        queue_req(OP_READ, 32'h1234_5678, 32'h0, 64'h0);

        // unmapped address: ignored
        wait_drained();
        write_reg(ADDR_UNMAPPED, 32'd1);
        queue_req(OP_ADD,  32'h0000_0044, 32'h0, 64'h44);

        run_phase(7'd64, 80, 75, 150);
        run_phase(7'd127, 80, 30, 100);
        run_phase(7'd1, 6, 40, 80);
        run_phase(7'd0, 10, 50, 60);
        steady = 1'b1;
        run_phase(7'($urandom_range(1, 64)), 20, 45, 120);
        steady = 1'b0;
        run_phase(7'd5, 12, 45, 100);
        run_phase(7'd64, 100, 35, 150);
        run_phase(7'($urandom_range(1, 64)), 40, 40, 140);

        wait_drained();
        if (fail_count == 0 && expected_resps.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/krt_pkg.sv
rtl/krt_cell.sv
rtl/keyed_record_table_unit.sv
tb/keyed_record_table_unit_test.sv
